// File: src/ileb_pkg.sv
package ileb_pkg;

	localparam int IdBits    = 64;
	localparam int ChunkBits = 8;
	localparam int GroupBits = 7;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_FLAG  = 3'b010,
		ST_BYTES = 3'b100
	} ileb_state_t;

	typedef struct packed {
		logic load;
		logic shift;
	} ileb_shf_ctl_t;

endpackage

// File: src/ileb_shifter.sv
module ileb_shifter
	import ileb_pkg::*;
(
	input  logic                 clk,
	input  ileb_shf_ctl_t        ctl,
	input  logic [IdBits-1:0]    load_value,
	output logic [ChunkBits-1:0] digit,
	output logic                 last
);

	logic [IdBits-1:0] rest_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rest_q <= load_value;
		end else if (ctl.shift) begin
			rest_q <= rest_q >> GroupBits;
		end
	end

	assign last  = (rest_q[IdBits-1:GroupBits] == '0);
	assign digit = {~last, rest_q[GroupBits-1:0]};

endmodule

// File: src/id_repeat_leb128_encoder.sv
// Identifier repeat encoder. Each accepted 64-bit id yields a 0 flag when it
// equals the stored id, or a 1 flag followed by its unsigned LEB128 bytes
// (low group first) when it differs; the first id after reset is only stored.
// Chunks leave one per cycle through an output register while res_stall is
// low. An id is taken only while no earlier id is still emitting; a change
// yields n LEB128 bytes (1 to 10), produced by a shift register that peels
// off one seven-bit group per cycle unless the output is stalled.
module id_repeat_leb128_encoder
	import ileb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 id_valid,
	output logic                 id_stall,
	input  logic [IdBits-1:0]    id,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [ChunkBits-1:0] chunk,
	output logic                 is_byte,
	output logic                 last
);

	ileb_state_t          state_q;
	logic                 have_prev_q;
	logic [IdBits-1:0]    prev_q;
	logic                 flag_q;
	logic                 out_valid_q;
	logic [ChunkBits-1:0] chunk_q;
	logic                 is_byte_q;
	logic                 last_q;

	ileb_shf_ctl_t        shf_ctl;
	logic [ChunkBits-1:0] shf_digit;
	logic                 shf_last;
	logic                 id_xfer;
	logic                 adv;

	assign id_stall = (state_q != ST_IDLE);
	assign id_xfer  = id_valid && !id_stall;
	assign adv      = !out_valid_q || !res_stall;

	assign shf_ctl.load  = id_xfer && have_prev_q && (id != prev_q);
	assign shf_ctl.shift = (state_q == ST_BYTES) && adv;

	ileb_shifter u_shifter (
		.clk        (clk),
		.ctl        (shf_ctl),
		.load_value (id),
		.digit      (shf_digit),
		.last       (shf_last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			have_prev_q <= 1'b0;
			prev_q      <= '0;
			flag_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= (state_q == ST_FLAG) || (state_q == ST_BYTES);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (id_xfer) begin
						if (!have_prev_q) begin
							have_prev_q <= 1'b1;
							prev_q      <= id;
						end else begin
							flag_q  <= (id != prev_q);
							prev_q  <= id;
							state_q <= ST_FLAG;
						end
					end
				end
				ST_FLAG: begin
					if (adv) begin
						state_q <= flag_q ? ST_BYTES : ST_IDLE;
					end
				end
				ST_BYTES: begin
					if (adv) begin
						if (shf_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (state_q == ST_FLAG) begin
				chunk_q   <= {{(ChunkBits-1){1'b0}}, flag_q};
				is_byte_q <= 1'b0;
				last_q    <= !flag_q;
			end else begin
				chunk_q   <= shf_digit;
				is_byte_q <= 1'b1;
				last_q    <= shf_last;
			end
		end
	end

	assign res_valid = out_valid_q;
	assign chunk     = chunk_q;
	assign is_byte   = is_byte_q;
	assign last      = last_q;

	a_busy_has_prev: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> have_prev_q)
		else $error("encoder busy without a stored id");

	a_change_then_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_stall && !is_byte && !last) |=> (res_valid && is_byte))
		else $error("change flag not followed by a byte");

	a_cont_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && is_byte) |-> (chunk[ChunkBits-1] == !last))
		else $error("continuation bit disagrees with last");

endmodule
